// File: rtl/xad_pkg.sv
// Package for the XA ADPCM sample decoder: shared widths, the decoded
// operation types passed from the front end to the back end, and the filter tables.
// No dependencies.
package xad_pkg;

	localparam int SampleW    = 16;
	localparam int QueueDepth = 2;

	// One channel's work, as classified by the front end.
	typedef struct packed {
		logic [1:0]         filter;
		logic [SampleW-1:0] base;
	} chan_op_t;

	// One queued item: the work for both channels.
	typedef struct packed {
		chan_op_t lch;
		chan_op_t rch;
	} item_t;

	// Positive prediction weight for the most recent sample.
	function automatic logic signed [7:0] pos_coef(input logic [1:0] filter);
		logic signed [7:0] c;
		case (filter)
			2'd0:    c = 8'sd0;
			2'd1:    c = 8'sd60;
			2'd2:    c = 8'sd115;
			2'd3:    c = 8'sd98;
			default: c = 8'sd0;
		endcase
		return c;
	endfunction

	// Negative prediction weight for the older sample.
	function automatic logic signed [7:0] neg_coef(input logic [1:0] filter);
		logic signed [7:0] c;
		case (filter)
			2'd0:    c = 8'sd0;
			2'd1:    c = 8'sd0;
			2'd2:    c = -8'sd52;
			2'd3:    c = -8'sd55;
			default: c = 8'sd0;
		endcase
		return c;
	endfunction

endpackage

// File: rtl/xa_adpcm_sample_decoder_top.sv
// XA ADPCM 4-bit sample decoder, top level.
// A pushed transaction enters the queue, then the result register once that is free or popped.
// Throughput: one transaction per cycle when results are popped; each take updates the history.
// Reset (arst_n low) clears the mode to mono, both channel histories, the queue and result valid.
// Depends on xad_pkg, xad_front, xad_queue and xad_back.
module xa_adpcm_sample_decoder_top import xad_pkg::*; #(
	parameter int QUEUE_DEPTH = QueueDepth
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         data_byte,
	input  logic [7:0]         header_first,
	input  logic [7:0]         header_second,
	input  logic               nibble_select,
	output logic               empty,
	input  logic               pop,
	output logic signed [15:0] left_sample,
	output logic signed [15:0] right_sample
);

	item_t front_item, queue_item;
	logic  queue_empty, queue_take;
	logic  [SampleW-1:0] left_raw, right_raw;

	// Front end: mode register and classification.
	xad_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.data_byte     (data_byte),
		.header_first  (header_first),
		.header_second (header_second),
		.nibble_select (nibble_select),
		.item          (front_item)
	);

	// Queue between front and back ends.
	xad_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_item (front_item),
		.full    (full),
		.rd_en   (queue_take),
		.rd_item (queue_item),
		.empty   (queue_empty)
	);

	// Back end: filter, saturation and result register.
	xad_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (queue_item),
		.item_valid   (!queue_empty),
		.item_take    (queue_take),
		.empty        (empty),
		.pop          (pop),
		.left_sample  (left_raw),
		.right_sample (right_raw)
	);

	assign left_sample  = $signed(left_raw);
	assign right_sample = $signed(right_raw);

endmodule

// File: rtl/xad_front.sv
// Front end of the XA ADPCM decoder: holds the mode register, picks the
// nibble and header for each channel and applies the header shift.
// Depends on xad_pkg.
module xad_front import xad_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic [7:0] data_byte,
	input  logic [7:0] header_first,
	input  logic [7:0] header_second,
	input  logic       nibble_select,
	output item_t      item
);

	logic       stereo_mode_q;
	logic [3:0] nib_l, nib_r;
	logic [7:0] hdr_l, hdr_r;

	// Mode register: user writes only while decoder is idle; not enforced.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stereo_mode_q <= 1'b0;
		end else if (cfg_we) begin
			stereo_mode_q <= cfg_wdata;
		end
	end

	// Route nibbles and headers to the two channels.
	always_comb begin
		if (stereo_mode_q) begin
			nib_l = data_byte[3:0];
			nib_r = data_byte[7:4];
			hdr_l = header_first;
			hdr_r = header_second;
		end else begin
			nib_l = nibble_select ? data_byte[7:4] : data_byte[3:0];
			nib_r = nib_l;
			hdr_l = header_first;
			hdr_r = header_first;
		end
	end

	// Place each nibble in the top bits and shift it down arithmetically.
	always_comb begin
		item.lch.filter = hdr_l[5:4];
		item.rch.filter = hdr_r[5:4];
		item.lch.base   = $unsigned($signed({nib_l, 12'b0}) >>> hdr_l[3:0]);
		item.rch.base   = $unsigned($signed({nib_r, 12'b0}) >>> hdr_r[3:0]);
	end

endmodule

// File: rtl/xad_queue.sv
// Short queue between the front and back ends of the XA ADPCM decoder.
// Depends on xad_pkg.
module xad_queue import xad_pkg::*; #(
	parameter int DEPTH = QueueDepth
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_en,
	input  item_t wr_item,
	output logic  full,
	input  logic  rd_en,
	output item_t rd_item,
	output logic  empty
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	item_t             mem_q [DEPTH];
	logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]   count_q;
	logic              do_wr, do_rd;

	assign full    = (count_q == CntW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_item = mem_q[rd_ptr_q];

	// Storage; entries need no reset.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/xad_back.sv
// Back end of the XA ADPCM decoder: applies the prediction filter against
// each channel's history, saturates, and holds the result register.
// Depends on xad_pkg.
module xad_back import xad_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  item_t               item,
	input  logic                item_valid,
	output logic                item_take,
	output logic                empty,
	input  logic                pop,
	output logic [SampleW-1:0]  left_sample,
	output logic [SampleW-1:0]  right_sample
);

	logic signed [SampleW-1:0] recent_q [2];
	logic signed [SampleW-1:0] older_q  [2];
	logic        [SampleW-1:0] result_q [2];
	logic                      out_valid_q;
	chan_op_t                  ops      [2];
	logic signed [SampleW-1:0] sample   [2];

	assign ops[0]    = item.lch;
	assign ops[1]    = item.rch;
	assign item_take = item_valid && (!out_valid_q || pop);

	// Prediction, add and saturation for both channels.
	always_comb begin
		for (int c = 0; c < 2; c++) begin
			logic signed [23:0] prod_pos, prod_neg;
			logic signed [24:0] pred;
			logic signed [24:0] pred_sh;
			logic signed [19:0] sum;
			prod_pos = 24'(pos_coef(ops[c].filter)) * 24'(recent_q[c]);
			prod_neg = 24'(neg_coef(ops[c].filter)) * 24'(older_q[c]);
			pred     = 25'(prod_pos) + 25'(prod_neg);
			pred_sh  = pred >>> 6;
			sum      = 20'($signed(ops[c].base)) + 20'(pred_sh);
			if (sum > 20'sd32767) begin
				sample[c] = 16'sh7fff;
			end else if (sum < -20'sd32768) begin
				sample[c] = 16'sh8000;
			end else begin
				sample[c] = sum[15:0];
			end
		end
	end

	// Channel history advances with every transaction taken from the queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 2; c++) begin
				recent_q[c] <= '0;
				older_q[c]  <= '0;
			end
		end else if (item_take) begin
			for (int c = 0; c < 2; c++) begin
				older_q[c]  <= recent_q[c];
				recent_q[c] <= sample[c];
			end
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (item_take) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (item_take) begin
			result_q[0] <= sample[0];
			result_q[1] <= sample[1];
		end
	end

	assign empty        = !out_valid_q;
	assign left_sample  = result_q[0];
	assign right_sample = result_q[1];

endmodule

// File: sim/xa_adpcm_sample_decoder_top_tb.sv
// Self-checking testbench for the XA ADPCM sample decoder top level.
// Drives random and directed transactions through the push/full queue port and checks the
// popped sample pairs against a predictor built into the bench. Depends on the decoder RTL only.
module xa_adpcm_sample_decoder_top_tb;

	localparam int CycleLimit = 200000;
	localparam int GapMax     = 11;

	// Prediction weights indexed by header filter field.
	localparam int RecentWeight[4] = '{0, 60, 115, 98};
	localparam int OlderWeight[4]  = '{0, 0, -52, -55};

	// Channel mode values for the one configuration register.
	localparam bit ModeMono   = 1'b0;
	localparam bit ModeStereo = 1'b1;

	typedef struct {
		logic [7:0] data_byte;
		logic [7:0] header_first;
		logic [7:0] header_second;
		logic       nibble_select;
	} adpcm_item_t;

	typedef struct {
		logic signed [15:0] left;
		logic signed [15:0] right;
	} sample_pair_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic               cfg_wdata = 1'b0;
	logic               push = 1'b0;
	logic               full;
	logic [7:0]         data_byte = 8'h00;
	logic [7:0]         header_first = 8'h00;
	logic [7:0]         header_second = 8'h00;
	logic               nibble_select = 1'b0;
	logic               empty;
	logic               pop = 1'b0;
	logic signed [15:0] left_sample;
	logic signed [15:0] right_sample;

	adpcm_item_t  pending_items[$];
	sample_pair_t expected_samples[$];

	// Predictor state: the mode and the two-sample history of each channel.
	bit stereo_cfg = ModeMono;
	int hist_recent[2] = '{0, 0};
	int hist_older[2]  = '{0, 0};

	bit item_taken = 1'b0;
	bit result_taken = 1'b0;
	bit send_steady = 1'b0;
	bit recv_steady = 1'b0;
	int send_wait = 0;
	int recv_wait = 0;
	int errors = 0;
	int cycle_count = 0;

	xa_adpcm_sample_decoder_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.push          (push),
		.full          (full),
		.data_byte     (data_byte),
		.header_first  (header_first),
		.header_second (header_second),
		.nibble_select (nibble_select),
		.empty         (empty),
		.pop           (pop),
		.left_sample   (left_sample),
		.right_sample  (right_sample)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Decode one nibble for one channel and advance that channel's history.
	function automatic int decode_nibble(logic [7:0] header, logic [3:0] nib, int ch);
		int shift;
		int filt;
		int n;
		int v;
		shift = header[3:0];
		filt  = header[5:4];
		n = {{28{nib[3]}}, nib};
		v = ((n * 4096) >>> shift)
			+ ((RecentWeight[filt] * hist_recent[ch] + OlderWeight[filt] * hist_older[ch]) >>> 6);
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		hist_older[ch]  = hist_recent[ch];
		hist_recent[ch] = v;
		return v;
	endfunction

	// Work out the sample pair that one accepted transaction produces.
	function automatic sample_pair_t predict_samples(adpcm_item_t it);
		sample_pair_t sp;
		logic [3:0] nib;
		if (stereo_cfg == ModeStereo) begin
			sp.left  = 16'(decode_nibble(it.header_first, it.data_byte[3:0], 0));
			sp.right = 16'(decode_nibble(it.header_second, it.data_byte[7:4], 1));
		end else begin
			nib = it.nibble_select ? it.data_byte[7:4] : it.data_byte[3:0];
			sp.left  = 16'(decode_nibble(it.header_first, nib, 0));
			sp.right = 16'(decode_nibble(it.header_first, nib, 1));
		end
		return sp;
	endfunction

	function automatic int draw_gap(bit steady);
		return steady ? 0 : $urandom_range(0, GapMax);
	endfunction

	// Random header, often loud (small shift, strong filter) to drive the history into saturation.
	function automatic logic [7:0] rand_header();
		logic [7:0] h;
		h = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 2) == 0) begin
			h[3:0] = 4'($urandom_range(0, 3));
			h[5:4] = 2'($urandom_range(2, 3));
		end
		return h;
	endfunction

	function automatic adpcm_item_t rand_item();
		adpcm_item_t it;
		logic [7:0] extremes[4];
		extremes = '{8'h77, 8'h88, 8'h78, 8'h87};
		it.data_byte     = 8'($urandom_range(0, 255));
		it.header_first  = rand_header();
		it.header_second = rand_header();
		it.nibble_select = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 7) == 0)
			it.data_byte = extremes[$urandom_range(0, 3)];
		return it;
	endfunction

	task automatic add_item(logic [7:0] d, logic [7:0] h1, logic [7:0] h2, logic sel);
		adpcm_item_t it;
		it.data_byte     = d;
		it.header_first  = h1;
		it.header_second = h2;
		it.nibble_select = sel;
		pending_items.push_back(it);
	endtask

	// Hold off until every queued transaction has been sent and every result has come back.
	task automatic drain_all();
		while (pending_items.size() != 0 || expected_samples.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write the mode register while the block is idle.
	task automatic write_mode(bit mode);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= mode;
		@(negedge clk);
		cfg_we     <= 1'b0;
		stereo_cfg = mode;
	endtask

	// Driver: feeds pending transactions onto the push port and paces the pop side.
	always @(negedge clk) begin : driver_proc
		bit nxt_push;
		bit nxt_pop;
		if (arst_n) begin
			nxt_push = push;
			if (item_taken) begin
				item_taken = 1'b0;
				void'(pending_items.pop_front());
				nxt_push = 1'b0;
				if ($urandom_range(0, 31) == 0)
					send_steady = !send_steady;
				send_wait = draw_gap(send_steady);
			end
			if (!nxt_push) begin
				if (send_wait > 0) begin
					send_wait--;
				end else if (pending_items.size() > 0) begin
					data_byte     <= pending_items[0].data_byte;
					header_first  <= pending_items[0].header_first;
					header_second <= pending_items[0].header_second;
					nibble_select <= pending_items[0].nibble_select;
					nxt_push = 1'b1;
				end
			end
			push <= nxt_push;

			if (result_taken) begin
				result_taken = 1'b0;
				if ($urandom_range(0, 31) == 0)
					recv_steady = !recv_steady;
				recv_wait = draw_gap(recv_steady);
			end
			if (recv_wait > 0) begin
				recv_wait--;
				nxt_pop = 1'b0;
			end else begin
				nxt_pop = 1'b1;
			end
			pop <= nxt_pop;
		end
	end

	// Monitor: checks each popped result, then records the transaction accepted at this edge.
	always @(posedge clk) begin : monitor_proc
		sample_pair_t want;
		adpcm_item_t  got_in;
		if (arst_n) begin
			if (pop && !empty) begin
				result_taken = 1'b1;
				if (expected_samples.size() == 0) begin
					$display("%0t: unexpected result left %0d right %0d", $time,
						left_sample, right_sample);
					errors++;
				end else begin
					want = expected_samples.pop_front();
					if (left_sample !== want.left) begin
						$display("%0t: left_sample expected %0d actual %0d", $time,
							want.left, left_sample);
						errors++;
					end
					if (right_sample !== want.right) begin
						$display("%0t: right_sample expected %0d actual %0d", $time,
							want.right, right_sample);
						errors++;
					end
				end
			end
			if (push && !full) begin
				got_in.data_byte     = data_byte;
				got_in.header_first  = header_first;
				got_in.header_second = header_second;
				got_in.nibble_select = nibble_select;
				expected_samples.push_back(predict_samples(got_in));
				item_taken = 1'b1;
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Stimulus sequence: directed mono and stereo cases, then random phases in both modes.
	initial begin : stimulus_proc
		bit phase_modes[6];
		phase_modes = '{ModeStereo, ModeMono, ModeStereo, ModeStereo, ModeMono, ModeMono};
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Mono at the reset mode: extremes of nibble and shift, all filters, saturation.
		add_item(8'h07, 8'h00, 8'h5A, 1'b0);
		add_item(8'h07, 8'h20, 8'hA5, 1'b0);
		add_item(8'h70, 8'hE0, 8'hFF, 1'b1);
		add_item(8'h08, 8'h00, 8'h00, 1'b0);
		add_item(8'h80, 8'h30, 8'h3C, 1'b1);
		add_item(8'hF8, 8'h1C, 8'h00, 1'b0);
		add_item(8'h8F, 8'h0D, 8'hFF, 1'b1);
		add_item(8'h1F, 8'hCE, 8'h12, 1'b0);
		add_item(8'h7F, 8'h3F, 8'h00, 1'b1);
		add_item(8'h00, 8'h10, 8'hFF, 1'b0);
		add_item(8'hFF, 8'hFF, 8'h00, 1'b1);
		drain_all();

		// Stereo: distinct headers per channel, saturation on both sides, large shifts.
		write_mode(ModeStereo);
		add_item(8'h87, 8'h00, 8'h00, 1'b0);
		add_item(8'h78, 8'h20, 8'h30, 1'b1);
		add_item(8'h77, 8'h20, 8'h20, 1'b0);
		add_item(8'h77, 8'hE0, 8'h60, 1'b1);
		add_item(8'h88, 8'h30, 8'h30, 1'b1);
		add_item(8'h88, 8'h3D, 8'h2F, 1'b0);
		add_item(8'hF0, 8'h0E, 8'hCF, 1'b1);
		add_item(8'h5A, 8'hFF, 8'h00, 1'b1);
		add_item(8'h00, 8'h10, 8'h10, 1'b0);
		drain_all();

		// Random phases; each one drains fully before the mode is rewritten.
		for (int p = 0; p < 6; p++) begin
			repeat (3) @(posedge clk);
			write_mode(phase_modes[p]);
			for (int i = 0; i < 175; i++)
				pending_items.push_back(rand_item());
			drain_all();
		end

		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: sim.f
rtl/xad_pkg.sv
rtl/xad_front.sv
rtl/xad_queue.sv
rtl/xad_back.sv
rtl/xa_adpcm_sample_decoder_top.sv
sim/xa_adpcm_sample_decoder_top_tb.sv
